// ===== sv/erm_pkg.sv =====
// Package: shared constants and functions for the Euler rotation matrix core.
`default_nettype none
package erm_pkg;
  localparam int WORK_FRAC = 30;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t [32];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
          32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
          32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
          32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
          32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
          32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
          32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    return t[i[4:0]];
  endfunction

  // Q30 product rounded back to Q30; operands are within +-2^31.
  function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
    return 34'(p >>> WORK_FRAC);
  endfunction
endpackage
`default_nettype wire

// ===== sv/erm_cordic.sv =====
// One-angle pipelined CORDIC sine/cosine unit with quadrant fold.
`default_nettype none
module erm_cordic import erm_pkg::*; #(
  parameter int ANGLE_BITS  = 16,
  parameter int TRIG_STAGES = 16
) (
  input  wire logic                         clk_i,
  input  wire logic [ANGLE_BITS-1:0]        angle_i,
  output logic signed [33:0]                cos_o,
  output logic signed [33:0]                sin_o
);
  localparam int N = (TRIG_STAGES < 32) ? TRIG_STAGES : 32;

  logic [31:0] t;
  assign t = {angle_i, {(32-ANGLE_BITS){1'b0}}};

  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [33:0] z_q [N+1];
  logic [1:0]         quad_q [N+1];
  logic               zero_q [N+1];

  always_ff @(posedge clk_i) begin
    x_q[0]    <= GAIN_Q30;
    y_q[0]    <= '0;
    z_q[0]    <= {4'b0, t[29:0]};
    quad_q[0] <= t[31:30];
    zero_q[0] <= (t == '0);
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      quad_q[i+1] <= quad_q[i];
      zero_q[i+1] <= zero_q[i];
      if (!z_q[i][33]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - $signed({2'b0, atan_turn(i)});
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + $signed({2'b0, atan_turn(i)});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (zero_q[N]) begin
      cos_o <= 34'sd1 <<< WORK_FRAC;
      sin_o <= '0;
    end else begin
      unique case (quad_q[N])
        2'd0: begin cos_o <= x_q[N];  sin_o <= y_q[N];  end
        2'd1: begin cos_o <= -y_q[N]; sin_o <= x_q[N];  end
        2'd2: begin cos_o <= -x_q[N]; sin_o <= -y_q[N]; end
        default: begin cos_o <= y_q[N]; sin_o <= -x_q[N]; end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/erm_matrix.sv =====
// Three-stage product pipeline forming the nine rotation entries.
`default_nettype none
module erm_matrix import erm_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                          clk_i,
  input  wire logic signed [33:0]            cx_i, sx_i, cy_i, sy_i, cz_i, sz_i,
  output logic signed [COEF_FRAC_BITS+1:0]   r_o [9]
);
  localparam int OB = COEF_FRAC_BITS + 2;
  localparam int SH = WORK_FRAC - COEF_FRAC_BITS;

  function automatic logic signed [OB-1:0] to_out(input logic signed [34:0] v);
    logic signed [35:0] r;
    r = (36'(v) + (36'sd1 <<< (SH - 1))) >>> SH;
    if (r > (36'sd1 <<< COEF_FRAC_BITS)) r = 36'sd1 <<< COEF_FRAC_BITS;
    if (r < -(36'sd1 <<< COEF_FRAC_BITS)) r = -(36'sd1 <<< COEF_FRAC_BITS);
    return r[OB-1:0];
  endfunction

  logic signed [33:0] czsy_q, szsy_q, cx1_q, sx1_q;
  logic signed [33:0] p00_q, p10_q, p21_q, p22_q, szcx_q, szsx_q, czcx_q, czsx_q;
  logic signed [33:0] my_q;
  logic signed [33:0] a01_q, a02_q, a11_q, a12_q;
  logic signed [33:0] b00_q, b10_q, b21_q, b22_q, b01_q, b02_q, b11_q, b12_q, b20_q;

  always_ff @(posedge clk_i) begin
    czsy_q <= qmul(cz_i, sy_i);
    szsy_q <= qmul(sz_i, sy_i);
    cx1_q <= cx_i; sx1_q <= sx_i;
    p00_q <= qmul(cz_i, cy_i);
    p10_q <= qmul(sz_i, cy_i);
    p21_q <= qmul(cy_i, sx_i);
    p22_q <= qmul(cy_i, cx_i);
    szcx_q <= qmul(sz_i, cx_i);
    szsx_q <= qmul(sz_i, sx_i);
    czcx_q <= qmul(cz_i, cx_i);
    czsx_q <= qmul(cz_i, sx_i);
    my_q <= -sy_i;

    a01_q <= qmul(czsy_q, sx1_q);
    a02_q <= qmul(czsy_q, cx1_q);
    a11_q <= qmul(szsy_q, sx1_q);
    a12_q <= qmul(szsy_q, cx1_q);
    b00_q <= p00_q; b10_q <= p10_q; b21_q <= p21_q; b22_q <= p22_q;
    b01_q <= szcx_q; b02_q <= szsx_q; b11_q <= czcx_q; b12_q <= czsx_q;
    b20_q <= my_q;

    r_o[0] <= to_out(35'(b00_q));
    r_o[1] <= to_out(35'(a01_q) - 35'(b01_q));
    r_o[2] <= to_out(35'(a02_q) + 35'(b02_q));
    r_o[3] <= to_out(35'(b10_q));
    r_o[4] <= to_out(35'(a11_q) + 35'(b11_q));
    r_o[5] <= to_out(35'(a12_q) - 35'(b12_q));
    r_o[6] <= to_out(35'(b20_q));
    r_o[7] <= to_out(35'(b21_q));
    r_o[8] <= to_out(35'(b22_q));
  end
endmodule
`default_nettype wire

// ===== sv/euler_rotation_matrix_core.sv =====
// Top level: ZYX Euler-angle rotation matrix core.
// Accepts one angle triple per cycle (busy_o is always low); the result
// appears with done_o high for one cycle, after the CORDIC input register,
// stage chain and output register plus the three product stages.
// The receiver cannot stall; results must be taken when done_o is high.
`default_nettype none
module euler_rotation_matrix_core import erm_pkg::*; #(
  parameter int ANGLE_BITS     = 16,
  parameter int COEF_FRAC_BITS = 14,
  parameter int TRIG_STAGES    = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [ANGLE_BITS-1:0]       angle_x_i,
  input  wire logic [ANGLE_BITS-1:0]       angle_y_i,
  input  wire logic [ANGLE_BITS-1:0]       angle_z_i,
  output logic                             done_o,
  output logic signed [COEF_FRAC_BITS+1:0] r00_o, r01_o, r02_o,
  output logic signed [COEF_FRAC_BITS+1:0] r10_o, r11_o, r12_o,
  output logic signed [COEF_FRAC_BITS+1:0] r20_o, r21_o, r22_o
);
  localparam int N   = (TRIG_STAGES < 32) ? TRIG_STAGES : 32;
  localparam int LAT = N + 5;

  logic signed [33:0] cx, sx, cy, sy, cz, sz;
  logic signed [COEF_FRAC_BITS+1:0] r [9];
  logic [LAT-1:0] vld_q;

  assign busy_o = 1'b0;

  erm_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_cx (
    .clk_i, .angle_i(angle_x_i), .cos_o(cx), .sin_o(sx));
  erm_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_cy (
    .clk_i, .angle_i(angle_y_i), .cos_o(cy), .sin_o(sy));
  erm_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_cz (
    .clk_i, .angle_i(angle_z_i), .cos_o(cz), .sin_o(sz));

  erm_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mat (
    .clk_i, .cx_i(cx), .sx_i(sx), .cy_i(cy), .sy_i(sy), .cz_i(cz), .sz_i(sz),
    .r_o(r));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  assign done_o = vld_q[LAT-1];
  assign r00_o = r[0]; assign r01_o = r[1]; assign r02_o = r[2];
  assign r10_o = r[3]; assign r11_o = r[4]; assign r12_o = r[5];
  assign r20_o = r[6]; assign r21_o = r[7]; assign r22_o = r[8];
endmodule
`default_nettype wire

// ===== sv/erm_checker.sv =====
// Port-level checker for the rotation matrix core, with bind.
`default_nettype none
module erm_checker #(
  parameter int COEF_FRAC_BITS = 14,
  parameter int TRIG_STAGES    = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o,
  input wire logic signed [COEF_FRAC_BITS+1:0] r00_o,
  input wire logic signed [COEF_FRAC_BITS+1:0] r20_o,
  input wire logic signed [COEF_FRAC_BITS+1:0] r22_o
);
  localparam int LAT = ((TRIG_STAGES < 32) ? TRIG_STAGES : 32) + 5;
  localparam logic signed [COEF_FRAC_BITS+1:0] ONE =
    (COEF_FRAC_BITS+2)'(1 <<< COEF_FRAC_BITS);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o) else $error("missing done");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (r00_o <= ONE && r00_o >= -ONE && r20_o <= ONE && r20_o >= -ONE
                && r22_o <= ONE && r22_o >= -ONE)) else $error("out of range");
endmodule

bind euler_rotation_matrix_core erm_checker #(
  .COEF_FRAC_BITS(COEF_FRAC_BITS),
  .TRIG_STAGES(TRIG_STAGES)) u_erm_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .r00_o, .r20_o, .r22_o);
`default_nettype wire

// ===== tb/euler_rotation_matrix_core_tb.sv =====
// Testbench for euler_rotation_matrix_core: angle triples checked against a fixed-point predictor.
module euler_rotation_matrix_core_tb;

  localparam int AW = 16;
  localparam int OW = 16;
  localparam int RAND_ITEMS = 1100;
  localparam int IDLE_LIMIT = 2000;

  typedef logic signed [OW-1:0] coef_t;
  typedef struct {
    logic [AW-1:0] ax, ay, az;
    coef_t         r[9];
  } matrix_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic [AW-1:0]  angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic           busy_o, done_o;
  coef_t          r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  euler_rotation_matrix_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .angle_x_i, .angle_y_i, .angle_z_i, .done_o,
    .r00_o, .r01_o, .r02_o, .r10_o, .r11_o, .r12_o, .r20_o, .r21_o, .r22_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  class matrix_scoreboard;
    matrix_t pending[$];
    int      errors = 0;
    int      accepted = 0;
    int      checked = 0;
    longint  atan_step[16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

    function void cos_sin(input logic [AW-1:0] ang, output longint c, output longint s);
      logic [31:0] t;
      longint x, y, z, xn;
      t = {ang, 16'h0000};
      if (t == 0) begin
        c = 64'sd1 <<< 30;
        s = 0;
        return;
      end
      x = 652032874;
      y = 0;
      z = longint'(t[29:0]);
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          xn = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - atan_step[i];
        end else begin
          xn = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + atan_step[i];
        end
        x = xn;
      end
      case (t[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint mul_q30(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function coef_t to_q14(input longint v);
      longint r;
      r = (v + (64'sd1 <<< 15)) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return coef_t'(r);
    endfunction

    function void note_input(input logic [AW-1:0] ax, ay, az);
      matrix_t m;
      longint cx, sx, cy, sy, cz, sz, czsy, szsy;
      cos_sin(ax, cx, sx);
      cos_sin(ay, cy, sy);
      cos_sin(az, cz, sz);
      czsy = mul_q30(cz, sy);
      szsy = mul_q30(sz, sy);
      m.ax = ax; m.ay = ay; m.az = az;
      m.r[0] = to_q14(mul_q30(cz, cy));
      m.r[1] = to_q14(mul_q30(czsy, sx) - mul_q30(sz, cx));
      m.r[2] = to_q14(mul_q30(czsy, cx) + mul_q30(sz, sx));
      m.r[3] = to_q14(mul_q30(sz, cy));
      m.r[4] = to_q14(mul_q30(szsy, sx) + mul_q30(cz, cx));
      m.r[5] = to_q14(mul_q30(szsy, cx) - mul_q30(cz, sx));
      m.r[6] = to_q14(-sy);
      m.r[7] = to_q14(mul_q30(cy, sx));
      m.r[8] = to_q14(mul_q30(cy, cx));
      pending.push_back(m);
      accepted++;
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(input coef_t got[9]);
      matrix_t m;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      m = pending.pop_front();
      checked++;
      for (int i = 0; i < 9; i++)
        if (got[i] !== m.r[i])
          report($sformatf("angles %0d/%0d/%0d r%0d%0d got %0d exp %0d",
                           $signed(m.ax), $signed(m.ay), $signed(m.az),
                           i / 3, i % 3, got[i], m.r[i]));
    endtask
  endclass

  matrix_scoreboard sb = new();
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    coef_t got[9];
    if (rst_ni && done_o) begin
      got = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
      sb.check_result(got);
    end
    if (rst_ni && ((start_i && !busy_o) || done_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("euler_rotation_matrix_core_tb: done, errors");
      $finish;
    end
  end

  task send_angles(input logic [AW-1:0] ax, ay, az);
    start_i   <= 1'b1;
    angle_x_i <= ax;
    angle_y_i <= ay;
    angle_z_i <= az;
    do @(posedge clk_i); while (busy_o);
    sb.note_input(ax, ay, az);
  endtask

  task pause(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function logic [AW-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return AW'($urandom_range(0, 3) << 14);
      2: return AW'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2);
      default: return AW'($urandom);
    endcase
  endfunction

  logic [AW-1:0] corner[10] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000,
                                16'h0001, 16'hFFFF, 16'h2000, 16'h3FFF, 16'hE000};

  initial begin
    int left, burst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of each axis alone, then combined
    for (int i = 0; i < 7; i++) send_angles(corner[i], '0, '0);
    for (int i = 1; i < 7; i++) send_angles('0, corner[i], '0);
    for (int i = 1; i < 7; i++) send_angles('0, '0, corner[i]);
    send_angles(16'h7FFF, 16'h8000, 16'h7FFF);
    send_angles(16'h4000, 16'h4000, 16'hC000);
    send_angles(16'h2000, 16'hE000, 16'h3FFF);
    pause(1);

    // hold off until the pipeline drains
    while (sb.pending.size() != 0) @(posedge clk_i);

    left = RAND_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++, left--)
        send_angles(pick_angle(), pick_angle(), pick_angle());
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 25));
      if (left == RAND_ITEMS / 2) pause(30);
    end
    pause(1);

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("covered %0d angle triples: axis corners, quadrant edges, random",
             sb.accepted);
    $display("%0d matrices checked", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("euler_rotation_matrix_core_tb: done, clean");
    else
      $display("euler_rotation_matrix_core_tb: done, errors");
    $finish;
  end

endmodule
